>>> rtl/core/tgs_pkg.sv
// Shared constants, types and codes of the topic-model token sampler.
package tgs_pkg;

  localparam int VOCAB      = 512;
  localparam int MAX_TOPICS = 16;
  localparam int TYPES      = 4;
  localparam int DOCS       = 256;

  localparam int WORD_W  = $clog2(VOCAB);
  localparam int DOC_W   = $clog2(DOCS);
  localparam int TYPE_W  = $clog2(TYPES);
  localparam int TOPIC_W = $clog2(MAX_TOPICS);
  localparam int KUSE_W  = TOPIC_W + 1;

  localparam int AW_DEPTH = VOCAB * MAX_TOPICS;
  localparam int DT_DEPTH = DOCS * MAX_TOPICS;
  localparam int TW_DEPTH = TYPES * VOCAB * MAX_TOPICS;
  localparam int TT_DEPTH = TYPES * MAX_TOPICS;
  localparam int CLR_W    = $clog2(TW_DEPTH);

  localparam int CNT_W = 16;
  localparam int TOT_W = 24;

  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_ART = 2'd0,
    CMD_LOAD_COM = 2'd1,
    CMD_RES_ART  = 2'd2,
    CMD_RES_COM  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ALPHA  = 3'd0,
    REG_ETA_A  = 3'd1,
    REG_ETA_C  = 3'd2,
    REG_VOCAB  = 3'd3,
    REG_TOPICS = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_WREQ, S_WDAT, S_MUL, S_PREP,
    S_DIV, S_STORE, S_THR, S_SCAN, S_UPRD, S_UPWR
  } state_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] eta_art;
    logic [15:0] eta_com;
    logic [9:0]  vocab;
    logic [4:0]  topics;
  } cfg_t;

  typedef struct packed {
    logic                comment;
    logic                resample;
    logic [DOC_W-1:0]    doc;
    logic [WORD_W-1:0]   word;
    logic [TYPE_W-1:0]   ctype;
    logic [TOPIC_W-1:0]  topic;
    logic [15:0]         uniform;
    logic [KUSE_W-1:0]   kuse;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

>>> rtl/core/tgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tgs_front.sv
// Command intake: classifies each word, clamps its topic fields and queues it.
module tgs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [tgs_pkg::DOC_W-1:0]  doc_index,
  input  logic [tgs_pkg::WORD_W-1:0] word_index,
  input  logic [tgs_pkg::TYPE_W-1:0] comment_type,
  input  logic [3:0]                 current_topic,
  input  logic [15:0]                uniform_draw,
  input  logic [4:0]                 topics,
  input  tgs_pkg::back_stat_t        stat,
  output tgs_pkg::item_t             q_item,
  output logic                       q_valid
);

  tgs_pkg::item_t                 q [tgs_pkg::QDEPTH];
  logic [tgs_pkg::QP_W-1:0]       wp;
  logic [tgs_pkg::QP_W-1:0]       rp;
  logic [tgs_pkg::QC_W-1:0]       cnt;
  tgs_pkg::item_t                 cls;
  logic [tgs_pkg::KUSE_W-1:0]     kuse;
  logic                           accept;

  always_comb begin
    if (topics == '0) begin
      kuse = tgs_pkg::KUSE_W'(1);
    end else if (topics > tgs_pkg::KUSE_W'(tgs_pkg::MAX_TOPICS)) begin
      kuse = tgs_pkg::KUSE_W'(tgs_pkg::MAX_TOPICS);
    end else begin
      kuse = topics;
    end
    cls.doc     = doc_index;
    cls.word    = word_index;
    cls.ctype   = comment_type;
    cls.uniform = uniform_draw;
    cls.kuse    = kuse;
    if ({1'b0, current_topic} >= kuse) begin
      cls.topic = tgs_pkg::TOPIC_W'(kuse - tgs_pkg::KUSE_W'(1));
    end else begin
      cls.topic = current_topic;
    end
    case (tgs_pkg::cmd_t'(cmd))
      tgs_pkg::CMD_LOAD_ART: begin
        cls.comment = 1'b0; cls.resample = 1'b0;
      end
      tgs_pkg::CMD_LOAD_COM: begin
        cls.comment = 1'b1; cls.resample = 1'b0;
      end
      tgs_pkg::CMD_RES_ART: begin
        cls.comment = 1'b0; cls.resample = 1'b1;
      end
      tgs_pkg::CMD_RES_COM: begin
        cls.comment = 1'b1; cls.resample = 1'b1;
      end
      default: begin
        cls.comment = 1'b0; cls.resample = 1'b0;
      end
    endcase
  end

  assign busy    = (cnt == tgs_pkg::QC_W'(tgs_pkg::QDEPTH)) || stat.clearing;
  assign accept  = start && !busy;
  assign q_valid = (cnt != '0);
  assign q_item  = q[rp];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= cls;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wp <= wp + tgs_pkg::QP_W'(1);
      end
      if (stat.pop) begin
        rp <= rp + tgs_pkg::QP_W'(1);
      end
      if (accept && !stat.pop) begin
        cnt <= cnt + tgs_pkg::QC_W'(1);
      end else if (!accept && stat.pop) begin
        cnt <= cnt - tgs_pkg::QC_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/tgs_back.sv
// Execution engine: count tables, per-topic weights with a serial divider, draw and update.
module tgs_back (
  input  logic                clk,
  input  logic                rst,
  input  tgs_pkg::cfg_t       cfg,
  input  tgs_pkg::item_t      q_item,
  input  logic                q_valid,
  output tgs_pkg::back_stat_t stat,
  output logic                done,
  output logic [3:0]          new_topic,
  output logic                count_error
);

  localparam int AW_AW = $clog2(tgs_pkg::AW_DEPTH);
  localparam int DT_AW = $clog2(tgs_pkg::DT_DEPTH);
  localparam int TW_AW = $clog2(tgs_pkg::TW_DEPTH);
  localparam int TT_AW = $clog2(tgs_pkg::TT_DEPTH);
  localparam int AT_AW = tgs_pkg::TOPIC_W;

  tgs_pkg::state_t              state;
  tgs_pkg::state_t              state_next;
  tgs_pkg::item_t               item;
  logic [tgs_pkg::TOPIC_W-1:0]  topic;
  logic [tgs_pkg::TOPIC_W-1:0]  k;
  logic                         err;
  logic [tgs_pkg::CLR_W-1:0]    clr;
  logic [24:0]                  n1;
  logic [25:0]                  n2;
  logic [32:0]                  den;
  logic [50:0]                  prod;
  logic [32:0]                  rem;
  logic [31:0]                  low;
  logic [31:0]                  quo;
  logic [4:0]                   dcnt;
  logic [31:0]                  wts [tgs_pkg::MAX_TOPICS];
  logic [35:0]                  sum;
  logic [35:0]                  thr;
  logic [35:0]                  run;

  logic                         clearing;
  logic                         wr_en;
  logic                         inc;
  logic [tgs_pkg::TOPIC_W-1:0]  tsel;
  logic [15:0]                  aw_q, tw_q, ad_q, cd_q, wc_q, dc_q;
  logic [23:0]                  at_q, tt_q, tc_q;
  logic [15:0]                  wc_new, dc_new;
  logic [23:0]                  tc_new;
  logic                         e_w, e_d, e_t, e_now;
  logic [15:0]                  eta;
  logic [25:0]                  veta;
  logic [16:0]                  dsum;
  logic                         sat;
  logic [33:0]                  rem_sh;
  logic [51:0]                  thr_prod;
  logic [35:0]                  run_n;
  logic                         hit;
  logic                         last;

  assign clearing = (state == tgs_pkg::S_CLEAR);
  assign wr_en    = (state == tgs_pkg::S_RD1) || (state == tgs_pkg::S_UPWR);
  assign inc      = (state == tgs_pkg::S_UPWR) || !item.resample;
  assign tsel     = (state == tgs_pkg::S_WREQ) ? k : topic;
  assign wc_q     = item.comment ? tw_q : aw_q;
  assign dc_q     = item.comment ? cd_q : ad_q;
  assign tc_q     = item.comment ? tt_q : at_q;
  assign eta      = item.comment ? cfg.eta_com : cfg.eta_art;
  assign veta     = cfg.vocab * eta;
  assign dsum     = {1'b0, ad_q} + {1'b0, cd_q};
  assign sat      = ({6'b0, prod[50:24]} >= den);
  assign rem_sh   = {rem, low[31]};
  assign thr_prod = item.uniform * sum;
  assign run_n    = run + {4'b0, wts[k]};
  assign hit      = run_n > thr;
  assign last     = ({1'b0, k} + tgs_pkg::KUSE_W'(1)) == item.kuse;

  always_comb begin
    e_w = 1'b0; e_d = 1'b0; e_t = 1'b0;
    wc_new = wc_q; dc_new = dc_q; tc_new = tc_q;
    if (inc) begin
      if (wc_q == '1) e_w = 1'b1; else wc_new = wc_q + 16'd1;
      if (dc_q == '1) e_d = 1'b1; else dc_new = dc_q + 16'd1;
      if (tc_q == '1) e_t = 1'b1; else tc_new = tc_q + 24'd1;
    end else begin
      if (wc_q == '0) e_w = 1'b1; else wc_new = wc_q - 16'd1;
      if (dc_q == '0) e_d = 1'b1; else dc_new = dc_q - 16'd1;
      if (tc_q == '0) e_t = 1'b1; else tc_new = tc_q - 24'd1;
    end
    e_now = e_w | e_d | e_t;
  end

  tgs_ram #(.WIDTH(tgs_pkg::CNT_W), .DEPTH(tgs_pkg::AW_DEPTH)) u_aw (
    .clk   (clk),
    .we    (clearing || (wr_en && !item.comment)),
    .waddr (clearing ? clr[AW_AW-1:0] : {item.word, topic}),
    .wdata (clearing ? '0 : wc_new),
    .raddr ({item.word, tsel}),
    .rdata (aw_q)
  );

  tgs_ram #(.WIDTH(tgs_pkg::CNT_W), .DEPTH(tgs_pkg::TW_DEPTH)) u_tw (
    .clk   (clk),
    .we    (clearing || (wr_en && item.comment)),
    .waddr (clearing ? clr[TW_AW-1:0] : {item.ctype, item.word, topic}),
    .wdata (clearing ? '0 : wc_new),
    .raddr ({item.ctype, item.word, tsel}),
    .rdata (tw_q)
  );

  tgs_ram #(.WIDTH(tgs_pkg::CNT_W), .DEPTH(tgs_pkg::DT_DEPTH)) u_ad (
    .clk   (clk),
    .we    (clearing || (wr_en && !item.comment)),
    .waddr (clearing ? clr[DT_AW-1:0] : {item.doc, topic}),
    .wdata (clearing ? '0 : dc_new),
    .raddr ({item.doc, tsel}),
    .rdata (ad_q)
  );

  tgs_ram #(.WIDTH(tgs_pkg::CNT_W), .DEPTH(tgs_pkg::DT_DEPTH)) u_cd (
    .clk   (clk),
    .we    (clearing || (wr_en && item.comment)),
    .waddr (clearing ? clr[DT_AW-1:0] : {item.doc, topic}),
    .wdata (clearing ? '0 : dc_new),
    .raddr ({item.doc, tsel}),
    .rdata (cd_q)
  );

  tgs_ram #(.WIDTH(tgs_pkg::TOT_W), .DEPTH(tgs_pkg::MAX_TOPICS)) u_at (
    .clk   (clk),
    .we    (clearing || (wr_en && !item.comment)),
    .waddr (clearing ? clr[AT_AW-1:0] : topic),
    .wdata (clearing ? '0 : tc_new),
    .raddr (tsel),
    .rdata (at_q)
  );

  tgs_ram #(.WIDTH(tgs_pkg::TOT_W), .DEPTH(tgs_pkg::TT_DEPTH)) u_tt (
    .clk   (clk),
    .we    (clearing || (wr_en && item.comment)),
    .waddr (clearing ? clr[TT_AW-1:0] : {item.ctype, topic}),
    .wdata (clearing ? '0 : tc_new),
    .raddr ({item.ctype, tsel}),
    .rdata (tt_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      tgs_pkg::S_CLEAR: if (clr == '1) state_next = tgs_pkg::S_IDLE;
      tgs_pkg::S_IDLE:  if (q_valid) state_next = tgs_pkg::S_RD0;
      tgs_pkg::S_RD0:   state_next = tgs_pkg::S_RD1;
      tgs_pkg::S_RD1:   state_next = item.resample ? tgs_pkg::S_WREQ : tgs_pkg::S_IDLE;
      tgs_pkg::S_WREQ:  state_next = tgs_pkg::S_WDAT;
      tgs_pkg::S_WDAT:  state_next = tgs_pkg::S_MUL;
      tgs_pkg::S_MUL:   state_next = tgs_pkg::S_PREP;
      tgs_pkg::S_PREP: begin
        state_next = (den == '0 || sat) ? tgs_pkg::S_STORE : tgs_pkg::S_DIV;
      end
      tgs_pkg::S_DIV:   if (dcnt == '1) state_next = tgs_pkg::S_STORE;
      tgs_pkg::S_STORE: state_next = last ? tgs_pkg::S_THR : tgs_pkg::S_WREQ;
      tgs_pkg::S_THR:   state_next = (sum == '0) ? tgs_pkg::S_UPRD : tgs_pkg::S_SCAN;
      tgs_pkg::S_SCAN:  if (hit || last) state_next = tgs_pkg::S_UPRD;
      tgs_pkg::S_UPRD:  state_next = tgs_pkg::S_UPWR;
      tgs_pkg::S_UPWR:  state_next = tgs_pkg::S_IDLE;
      default:          state_next = tgs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    stat.pop      = (state == tgs_pkg::S_IDLE) && q_valid;
    stat.clearing = clearing;
    done          = (state == tgs_pkg::S_UPWR) ||
                    ((state == tgs_pkg::S_RD1) && !item.resample);
    new_topic     = topic;
    count_error   = err | e_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgs_pkg::S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr <= clr + tgs_pkg::CLR_W'(1);
      end
    end

    case (state)
      tgs_pkg::S_IDLE: begin
        item  <= q_item;
        topic <= q_item.topic;
        err   <= 1'b0;
        k     <= '0;
        sum   <= '0;
      end
      tgs_pkg::S_RD1: err <= err | e_now;
      tgs_pkg::S_UPWR: err <= err | e_now;
      tgs_pkg::S_WDAT: begin
        n1  <= {9'b0, eta} + {1'b0, wc_q, 8'b0};
        n2  <= {10'b0, cfg.alpha} + {1'b0, dsum, 8'b0};
        den <= {7'b0, veta} + {1'b0, tc_q, 8'b0};
      end
      tgs_pkg::S_MUL: prod <= n1 * n2;
      tgs_pkg::S_PREP: begin
        rem  <= {6'b0, prod[50:24]};
        low  <= {prod[23:0], 8'b0};
        dcnt <= '0;
        quo  <= (den != '0 && sat) ? '1 : '0;
      end
      tgs_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= 33'(rem_sh - {1'b0, den});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh[32:0];
          quo <= {quo[30:0], 1'b0};
        end
        low  <= {low[30:0], 1'b0};
        dcnt <= dcnt + 5'd1;
      end
      tgs_pkg::S_STORE: begin
        wts[k] <= quo;
        sum    <= sum + {4'b0, quo};
        k      <= last ? '0 : k + tgs_pkg::TOPIC_W'(1);
      end
      tgs_pkg::S_THR: begin
        thr <= thr_prod[51:16];
        run <= '0;
        k   <= '0;
      end
      tgs_pkg::S_SCAN: begin
        run <= run_n;
        if (hit) begin
          topic <= k;
        end
        k <= k + tgs_pkg::TOPIC_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/topic_model_gibbs_token_sampler.sv
// Top level of the topic-model token sampler: configuration registers, intake and engine.
//
// Channel   Handshake                 Fields
// command   start / busy              cmd doc_index word_index comment_type current_topic
//                                     uniform_draw
// config    cfg_valid / cfg_ready     cfg_index cfg_data
// result    done (one-cycle strobe)   new_topic count_error
//
// A load passes from the queue head through the read states RD0 and RD1 to its result. A
// resample computes a weight for each topic in use and then scans those topics: each topic
// costs a table read, one multiply and a 32-step shift-subtract divider, which sets the rate.
// A topic whose denominator is zero or whose weight saturates skips the divider.
// After reset the count tables are swept to zero, with busy high.
// A two-word queue lets commands be taken while the engine works; results cannot be
// held off by the receiver.
module topic_model_gibbs_token_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  doc_index,
  input  logic [8:0]  word_index,
  input  logic [1:0]  comment_type,
  input  logic [3:0]  current_topic,
  input  logic [15:0] uniform_draw,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [3:0]  new_topic,
  output logic        count_error
);

  tgs_pkg::cfg_t       cfg;
  tgs_pkg::back_stat_t stat;
  tgs_pkg::item_t      q_item;
  logic                q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha   <= 16'd256;
      cfg.eta_art <= 16'd26;
      cfg.eta_com <= 16'd26;
      cfg.vocab   <= 10'd512;
      cfg.topics  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (tgs_pkg::cfg_reg_t'(cfg_index))
        tgs_pkg::REG_ALPHA:  cfg.alpha   <= cfg_data;
        tgs_pkg::REG_ETA_A:  cfg.eta_art <= cfg_data;
        tgs_pkg::REG_ETA_C:  cfg.eta_com <= cfg_data;
        tgs_pkg::REG_VOCAB:  cfg.vocab   <= cfg_data[9:0];
        tgs_pkg::REG_TOPICS: cfg.topics  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  tgs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .doc_index     (doc_index),
    .word_index    (word_index),
    .comment_type  (comment_type),
    .current_topic (current_topic),
    .uniform_draw  (uniform_draw),
    .topics        (cfg.topics),
    .stat          (stat),
    .q_item        (q_item),
    .q_valid       (q_valid)
  );

  tgs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .stat        (stat),
    .done        (done),
    .new_topic   (new_topic),
    .count_error (count_error)
  );

endmodule

>>> rtl/core/tgs_checker.sv
// Port-level checks on the token sampler, bound to its top level.
module tgs_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic       cfg_ready
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held two cycles");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst) busy |-> cfg_ready)
    else $error("configuration port blocked while busy");

endmodule

bind topic_model_gibbs_token_sampler tgs_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);

>>> tb/topic_model_gibbs_token_sampler_tb.sv
// Self-checking testbench for the topic-model token sampler: queued stimulus, counting predictor.
`timescale 1ns / 100ps

module topic_model_gibbs_token_sampler_tb;

  typedef struct {
    bit                  is_cfg;
    bit                  no_gap;
    tgs_pkg::cmd_t       cmd;
    logic [7:0]          doc;
    logic [8:0]          word;
    logic [1:0]          ctype;
    logic [3:0]          topic;
    logic [15:0]         uniform;
    tgs_pkg::cfg_reg_t   idx;
    logic [15:0]         data;
  } word_t;

  typedef struct {
    logic [3:0] topic;
    logic       err;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = 2'd0;
  logic [7:0]  doc_index = 8'd0;
  logic [8:0]  word_index = 9'd0;
  logic [1:0]  comment_type = 2'd0;
  logic [3:0]  current_topic = 4'd0;
  logic [15:0] uniform_draw = 16'd0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        done;
  logic [3:0]  new_topic;
  logic        count_error;

  topic_model_gibbs_token_sampler dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  word_t   pending[$];
  sample_t expected_samples[$];
  int      failures = 0;
  int      gap = 0;
  int      settle = 0;
  bit      quiet_part = 0;

  logic [15:0] alpha_q = 16'd256, eta_art_q = 16'd26, eta_com_q = 16'd26;
  logic [9:0]  vocab_q = 10'd512;
  logic [4:0]  topics_q = 5'd16;

  bit [15:0] art_word_cnt[tgs_pkg::AW_DEPTH];
  bit [15:0] art_doc_cnt[tgs_pkg::DT_DEPTH];
  bit [23:0] art_total[tgs_pkg::MAX_TOPICS];
  bit [15:0] com_doc_cnt[tgs_pkg::DT_DEPTH];
  bit [15:0] type_word_cnt[tgs_pkg::TW_DEPTH];
  bit [23:0] type_total[tgs_pkg::TT_DEPTH];

  function automatic void step16(inout bit [15:0] c, input bit up, inout bit e);
    if (up) begin
      if (c == 16'hFFFF) e = 1'b1; else c = c + 16'd1;
    end else begin
      if (c == 16'd0) e = 1'b1; else c = c - 16'd1;
    end
  endfunction

  function automatic void step24(inout bit [23:0] c, input bit up, inout bit e);
    if (up) begin
      if (c == 24'hFFFFFF) e = 1'b1; else c = c + 24'd1;
    end else begin
      if (c == 24'd0) e = 1'b1; else c = c - 24'd1;
    end
  endfunction

  function automatic void move_token(bit com, int wb, int db, int tb, int k, bit up,
                                     inout bit e);
    if (com) begin
      step16(type_word_cnt[wb + k], up, e);
      step16(com_doc_cnt[db + k], up, e);
      step24(type_total[tb + k], up, e);
    end else begin
      step16(art_word_cnt[wb + k], up, e);
      step16(art_doc_cnt[db + k], up, e);
      step24(art_total[k], up, e);
    end
  endfunction

  function automatic sample_t sample_token(word_t w);
    sample_t r;
    bit e, com;
    int kuse, cur, topic, wb, db, tb;
    longint unsigned eta, sum, run, thr, n1, n2, den, wt, wc, tot;
    longint unsigned wts[tgs_pkg::MAX_TOPICS];
    e = 0;
    kuse = topics_q;
    if (kuse < 1) kuse = 1;
    if (kuse > tgs_pkg::MAX_TOPICS) kuse = tgs_pkg::MAX_TOPICS;
    cur = w.topic;
    if (cur >= kuse) cur = kuse - 1;
    topic = cur;
    com = w.cmd[0];
    db = w.doc * tgs_pkg::MAX_TOPICS;
    wb = com ? (w.ctype * tgs_pkg::VOCAB + w.word) * tgs_pkg::MAX_TOPICS
             : w.word * tgs_pkg::MAX_TOPICS;
    tb = com ? w.ctype * tgs_pkg::MAX_TOPICS : 0;
    if (w.cmd[1]) begin
      eta = com ? eta_com_q : eta_art_q;
      move_token(com, wb, db, tb, cur, 0, e);
      sum = 0;
      for (int k = 0; k < kuse; k++) begin
        wc = com ? type_word_cnt[wb + k] : art_word_cnt[wb + k];
        tot = com ? type_total[tb + k] : art_total[k];
        n1 = eta + (wc << 8);
        n2 = alpha_q + ((64'(art_doc_cnt[db + k]) + com_doc_cnt[db + k]) << 8);
        den = vocab_q * eta + (tot << 8);
        if (den == 0) wt = 0;
        else wt = ((n1 * n2) << 8) / den;
        if (wt > 64'hFFFFFFFF) wt = 64'hFFFFFFFF;
        wts[k] = wt;
        sum += wt;
      end
      if (sum != 0) begin
        thr = (w.uniform * sum) >> 16;
        run = 0;
        for (int k = 0; k < kuse; k++) begin
          run += wts[k];
          if (run > thr) begin
            topic = k;
            break;
          end
        end
      end
    end
    move_token(com, wb, db, tb, topic, 1, e);
    r.topic = topic[3:0];
    r.err = e;
    return r;
  endfunction

  always @(posedge clk) begin
    logic  nstart, ncfg;
    word_t h;
    nstart = start;
    ncfg = cfg_valid;
    if (rst) begin
      nstart = 0;
      ncfg = 0;
    end else begin
      if (start && !busy) begin
        expected_samples.push_back(sample_token(pending[0]));
        if (!pending[0].no_gap && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        void'(pending.pop_front());
        nstart = 0;
      end
      if (cfg_valid && cfg_ready) begin
        case (pending[0].idx)
          tgs_pkg::REG_ALPHA:  alpha_q = pending[0].data;
          tgs_pkg::REG_ETA_A:  eta_art_q = pending[0].data;
          tgs_pkg::REG_ETA_C:  eta_com_q = pending[0].data;
          tgs_pkg::REG_VOCAB:  vocab_q = pending[0].data[9:0];
          tgs_pkg::REG_TOPICS: topics_q = pending[0].data[4:0];
          default: ;
        endcase
        void'(pending.pop_front());
        ncfg = 0;
      end
      settle = (expected_samples.size() == 0 && !nstart) ? settle + 1 : 0;
      if (!nstart && !ncfg && pending.size() > 0) begin
        h = pending[0];
        if (gap > 0) begin
          gap--;
        end else if (!h.is_cfg) begin
          cmd <= h.cmd;
          doc_index <= h.doc;
          word_index <= h.word;
          comment_type <= h.ctype;
          current_topic <= h.topic;
          uniform_draw <= h.uniform;
          nstart = 1;
        end else if (settle >= 8) begin
          cfg_index <= h.idx;
          cfg_data <= h.data;
          ncfg = 1;
        end
      end
    end
    start <= nstart;
    cfg_valid <= ncfg;
  end

  always @(posedge clk) begin
    sample_t x;
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        $error("result word with no expectation: new_topic %0d", new_topic);
        failures++;
      end else begin
        x = expected_samples.pop_front();
        if (new_topic !== x.topic) begin
          $error("new_topic expected %0d actual %0d", x.topic, new_topic);
          failures++;
        end
        if (count_error !== x.err) begin
          $error("count_error expected %0d actual %0d", x.err, count_error);
          failures++;
        end
      end
    end
  end

  task automatic add_cmd(tgs_pkg::cmd_t c, int d, int w, int t, int tp, int u);
    word_t x;
    x.is_cfg = 1'b0;
    x.no_gap = quiet_part;
    x.cmd = c;
    x.doc = 8'(d);
    x.word = 9'(w);
    x.ctype = 2'(t);
    x.topic = 4'(tp);
    x.uniform = 16'(u);
    x.idx = tgs_pkg::REG_ALPHA;
    x.data = '0;
    pending.push_back(x);
  endtask

  task automatic add_cfg(int a, int ea, int ec, int v, int k);
    word_t x;
    x = '{default: 0, cmd: tgs_pkg::CMD_LOAD_ART, idx: tgs_pkg::REG_ALPHA};
    x.is_cfg = 1'b1;
    x.idx = tgs_pkg::REG_ALPHA;  x.data = 16'(a);  pending.push_back(x);
    x.idx = tgs_pkg::REG_ETA_A;  x.data = 16'(ea); pending.push_back(x);
    x.idx = tgs_pkg::REG_ETA_C;  x.data = 16'(ec); pending.push_back(x);
    x.idx = tgs_pkg::REG_VOCAB;  x.data = 16'(v);  pending.push_back(x);
    x.idx = tgs_pkg::REG_TOPICS; x.data = 16'(k);  pending.push_back(x);
  endtask

  task automatic rand_phase(int n, int ndocs, int nwords);
    tgs_pkg::cmd_t c;
    int d, w;
    for (int i = 0; i < n; i++) begin
      c = tgs_pkg::cmd_t'({$urandom_range(0, 99) >= 35, 1'($urandom)});
      d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ndocs - 1);
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) : $urandom_range(0, nwords - 1);
      add_cmd(c, d, w, $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    add_cmd(tgs_pkg::CMD_LOAD_ART, 255, 511, 0, 15, 65535);
    add_cmd(tgs_pkg::CMD_LOAD_ART, 0, 0, 3, 0, 0);
    add_cmd(tgs_pkg::CMD_LOAD_COM, 255, 511, 3, 15, 0);
    add_cmd(tgs_pkg::CMD_LOAD_COM, 0, 0, 0, 0, 65535);
    add_cmd(tgs_pkg::CMD_LOAD_ART, 0, 0, 0, 7, 0);
    add_cmd(tgs_pkg::CMD_RES_ART, 0, 0, 0, 0, 0);
    add_cmd(tgs_pkg::CMD_RES_ART, 0, 0, 2, 7, 65535);
    add_cmd(tgs_pkg::CMD_RES_ART, 255, 511, 0, 15, 32768);
    add_cmd(tgs_pkg::CMD_RES_COM, 255, 511, 3, 15, 0);
    add_cmd(tgs_pkg::CMD_RES_COM, 0, 0, 0, 0, 65535);
    add_cmd(tgs_pkg::CMD_RES_ART, 17, 99, 0, 3, 12345);
    add_cmd(tgs_pkg::CMD_RES_COM, 17, 99, 1, 3, 54321);
    add_cmd(tgs_pkg::CMD_LOAD_COM, 3, 5, 2, 9, 0);
    add_cmd(tgs_pkg::CMD_RES_COM, 3, 5, 2, 9, 40000);
    rand_phase(220, 4, 8);
    add_cfg(0, 65535, 0, 1, 1);
    add_cmd(tgs_pkg::CMD_RES_ART, 1, 1, 0, 15, 65535);
    add_cmd(tgs_pkg::CMD_RES_COM, 1, 1, 1, 9, 0);
    rand_phase(200, 4, 8);
    add_cfg(65535, 0, 65535, 512, 16);
    rand_phase(230, 4, 8);
    add_cfg(0, 0, 0, 0, 0);
    add_cmd(tgs_pkg::CMD_RES_COM, 200, 300, 2, 5, 30000);
    add_cmd(tgs_pkg::CMD_RES_ART, 201, 301, 0, 5, 30000);
    rand_phase(200, 2, 4);
    add_cfg($urandom, $urandom, $urandom, 1023, 31);
    rand_phase(230, 4, 8);
    add_cfg(256, 26, 26, 512, 4);
    rand_phase(230, 3, 6);
    add_cfg($urandom, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(1, 512), $urandom_range(1, 16));
    rand_phase(150, 4, 8);
    quiet_part = 1;
    rand_phase(150, 4, 8);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && expected_samples.size() == 0);
    repeat (50) @(posedge clk);
    if (failures == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tgs_pkg.sv
rtl/core/tgs_ram.sv
rtl/core/tgs_front.sv
rtl/core/tgs_back.sv
rtl/core/topic_model_gibbs_token_sampler.sv
rtl/core/tgs_checker.sv
tb/topic_model_gibbs_token_sampler_tb.sv
